@@ rtl/assert_macros.svh @@
// assertion macros shared by the websocket frame decoder rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge once reset is released
`define WSFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// a condition that must never hold outside reset
`define WSFD_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ rtl/wsfd_pkg.sv @@
// shared types and constants of the websocket frame decoder
// no dependencies
`default_nettype none

package wsfd_pkg;

  localparam int unsigned LenW      = 63;
  localparam logic [6:0]  LenCode16 = 7'd126;
  localparam logic [6:0]  LenCode64 = 7'd127;
  localparam logic [7:0]  LenCodeMsk = 8'h7F;

  // depth of the queue between parser and output stage
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // one payload word as handed from parser to output stage
  typedef struct packed {
    logic [7:0]      data;
    logic [7:0]      key;
    logic            last;
    logic [3:0]      opcode;
    logic            fin;
    logic [LenW-1:0] length;
  } wsfd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wsfd_qstat_t;

endpackage

`default_nettype wire

@@ rtl/websocket_frame_decoder.sv @@
// byte-serial websocket deframer: one stream word per clock in, one unmasked
// payload word out per payload byte; header and key words produce nothing.
// a taken payload word is written to the queue, then to the output register.
// input: one word per clock, stalled only by a full queue in the payload phase.
// the parser keeps taking header words while the output side stalls.
// reset (rst_ni low, async): parser waits for a first header word, queue empty.
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_decoder
  import wsfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [7:0] payload_byte, [70:8] frame_length, pad
  output logic             m_axis_tlast,   // last_of_frame
  output logic [4:0]       m_axis_tuser    // [3:0] frame_opcode, [4] frame_fin
);

  wsfd_entry_t     push_entry;
  wsfd_entry_t     head;
  wsfd_qstat_t     qstat;
  logic            push;
  logic            pop;
  logic            in_fire;
  logic [7:0]      out_byte;
  logic [3:0]      out_opcode;
  logic            out_fin;
  logic [LenW-1:0] out_length;

  wsfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .qstat_i      (qstat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  wsfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (qstat)
  );

  wsfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .out_last_o   (m_axis_tlast),
    .out_opcode_o (out_opcode),
    .out_fin_o    (out_fin),
    .out_length_o (out_length)
  );

  assign m_axis_tdata = {1'b0, out_length, out_byte};
  assign m_axis_tuser = {out_fin, out_opcode};

  assign in_fire = s_axis_tvalid && s_axis_tready;

  `WSFD_NEVER(a_no_overflow, clk_i, rst_ni, push && qstat.full, "queue overflow")
  `WSFD_NEVER(a_no_underflow, clk_i, rst_ni, pop && qstat.empty, "queue underflow")
  `WSFD_NEVER(a_stat_sane, clk_i, rst_ni, qstat.full && qstat.empty, "queue full and empty")
  `WSFD_ASSERT(a_push_needs_input, clk_i, rst_ni, push |-> in_fire, "push without input word")

endmodule

`default_nettype wire

@@ rtl/wsfd_front.sv @@
// header parser: takes raw stream words, tracks length and mask key,
// and pushes one entry per payload byte; uses wsfd_pkg
`default_nettype none

module wsfd_front
  import wsfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire wsfd_qstat_t qstat_i,
  output logic             push_o,
  output wsfd_entry_t      push_entry_o
);

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExt16,
    PhExt64,
    PhKey,
    PhPayload
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [3:0]      opcode_q, opcode_d;
  logic            fin_q, fin_d;
  logic            masked_q, masked_d;
  logic [3:0]      hbc_q, hbc_d;
  logic [LenW-1:0] total_q, total_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [31:0]     key_q, key_d;
  logic [1:0]      kidx_q, kidx_d;

  logic            accept;
  logic [3:0]      hbc_inc;
  logic [LenW-1:0] total_shift;
  logic [3:0]      ext_limit;
  logic [7:0]      key_byte;
  logic            last;

  function automatic phase_e after_length(input logic masked, input logic [LenW-1:0] len);
    phase_e ph;
    if (masked) begin
      ph = PhKey;
    end else if (len == '0) begin
      ph = PhHdr0;
    end else begin
      ph = PhPayload;
    end
    return ph;
  endfunction

  assign in_ready_o = !((phase_q == PhPayload) && qstat_i.full);
  assign accept     = in_valid_i && in_ready_o;

  assign hbc_inc     = hbc_q + 4'd1;
  assign total_shift = {total_q[LenW-9:0], in_byte_i};
  assign ext_limit   = (phase_q == PhExt16) ? 4'd2 : 4'd8;
  assign last        = (rem_q == {{(LenW-1){1'b0}}, 1'b1}) || (rem_q == '0);

  // first key word received sits in the top byte
  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    fin_d    = fin_q;
    masked_d = masked_q;
    hbc_d    = hbc_q;
    total_d  = total_q;
    rem_d    = rem_q;
    key_d    = key_q;
    kidx_d   = kidx_q;
    push_o   = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PhHdr1: begin
          masked_d = in_byte_i[7];
          key_d    = '0;
          kidx_d   = '0;
          hbc_d    = '0;
          if (in_byte_i[6:0] == LenCode16) begin
            total_d = '0;
            phase_d = PhExt16;
          end else if (in_byte_i[6:0] == LenCode64) begin
            total_d = '0;
            phase_d = PhExt64;
          end else begin
            total_d = {{(LenW-7){1'b0}}, in_byte_i[6:0] & LenCodeMsk[6:0]};
            rem_d   = total_d;
            phase_d = after_length(in_byte_i[7], total_d);
          end
        end
        PhExt16, PhExt64: begin
          total_d = total_shift;
          hbc_d   = hbc_inc;
          if (hbc_inc >= ext_limit) begin
            rem_d   = total_shift;
            hbc_d   = '0;
            phase_d = after_length(masked_q, total_shift);
          end
        end
        PhKey: begin
          key_d = {key_q[23:0], in_byte_i};
          hbc_d = hbc_inc;
          if (hbc_inc >= 4'd4) begin
            hbc_d   = '0;
            phase_d = (total_q != '0) ? PhPayload : PhHdr0;
          end
        end
        PhPayload: begin
          push_o = 1'b1;
          kidx_d = kidx_q + 2'd1;
          rem_d  = (rem_q == '0) ? rem_q : rem_q - {{(LenW-1){1'b0}}, 1'b1};
          if (last) begin
            phase_d = PhHdr0;
          end
        end
        default: begin
          fin_d    = in_byte_i[7];
          opcode_d = in_byte_i[3:0];
          phase_d  = PhHdr1;
        end
      endcase
    end
  end

  always_comb begin
    push_entry_o.data   = in_byte_i;
    push_entry_o.key    = key_byte;
    push_entry_o.last   = last;
    push_entry_o.opcode = opcode_q;
    push_entry_o.fin    = fin_q;
    push_entry_o.length = total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      opcode_q <= '0;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      hbc_q    <= '0;
      total_q  <= '0;
      rem_q    <= '0;
      key_q    <= '0;
      kidx_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      hbc_q    <= hbc_d;
      total_q  <= total_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      kidx_q   <= kidx_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/wsfd_queue.sv @@
// short fifo of payload entries between parser and output stage
// uses wsfd_pkg for the entry type and depth
`default_nettype none

module wsfd_queue
  import wsfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire wsfd_entry_t push_entry_i,
  input  wire logic        pop_i,
  output wsfd_entry_t      head_o,
  output wsfd_qstat_t      stat_o
);

  wsfd_entry_t      mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign head_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/wsfd_back.sv @@
// output stage: unmasks queued payload words into the output register
// uses wsfd_pkg for the entry and status types
`default_nettype none

module wsfd_back
  import wsfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire wsfd_entry_t head_i,
  input  wire wsfd_qstat_t qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic [3:0]       out_opcode_o,
  output logic             out_fin_o,
  output logic [LenW-1:0]  out_length_o
);

  logic            valid_q, valid_d;
  logic [7:0]      byte_q;
  logic            last_q;
  logic [3:0]      opcode_q;
  logic            fin_q;
  logic [LenW-1:0] length_q;

  // refill whenever the register is empty or being drained
  assign pop_o = !qstat_i.empty && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q   <= head_i.data ^ head_i.key;
      last_q   <= head_i.last;
      opcode_q <= head_i.opcode;
      fin_q    <= head_i.fin;
      length_q <= head_i.length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign out_last_o   = last_q;
  assign out_opcode_o = opcode_q;
  assign out_fin_o    = fin_q;
  assign out_length_o = length_q;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for websocket_frame_decoder: byte streams of whole frames
// go in, unmasked payload words are predicted in the bench and checked on the way out
// depends on rtl/wsfd_pkg.sv, rtl/websocket_frame_decoder.sv and its submodules
module tb;
  import wsfd_pkg::*;

  localparam int unsigned StreamWords = 1600;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned ReportMax   = 10;

  typedef enum logic [2:0] {
    PhHdr0, PhHdr1, PhExt16, PhExt64, PhKey, PhPayload
  } parse_phase_e;

  typedef enum int {LenDirect, LenExt16, LenExt64} len_form_e;

  typedef struct packed {
    logic [7:0]      data;
    logic            last;
    logic [3:0]      opcode;
    logic            fin;
    logic [LenW-1:0] length;
  } payload_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] stream_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;           // [7:0] payload_byte, [70:8] frame_length, pad
  logic        m_axis_tlast;           // last_of_frame
  logic [4:0]  m_axis_tuser;           // [3:0] frame_opcode, [4] frame_fin

  websocket_frame_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  logic [7:0]    stream_q[$];
  payload_word_t payload_expect_q[$];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_on = 1'b0;
  logic        in_fire = 1'b0;

  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_predicted = 0;
  int unsigned n_errors = 0;
  int unsigned n_frames = 0;
  int unsigned n_masked = 0;
  int unsigned n_empty = 0;
  int unsigned idle_cycles = 0;

  // deframer shadow state
  parse_phase_e    ph = PhHdr0;
  logic [3:0]      hdr_op = '0;
  logic            hdr_fin = 1'b0;
  logic            masked = 1'b0;
  logic [3:0]      hdr_cnt = '0;
  logic [LenW-1:0] tot_len = '0;
  logic [LenW-1:0] rem_len = '0;
  logic [31:0]     key = '0;
  logic [1:0]      key_idx = '0;

  function automatic void length_known();
    rem_len = tot_len;
    hdr_cnt = '0;
    if (masked) ph = PhKey;
    else if (tot_len == '0) ph = PhHdr0;
    else ph = PhPayload;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    payload_word_t w;
    case (ph)
      PhHdr1: begin
        masked  = b[7];
        tot_len = '0;
        key     = '0;
        key_idx = '0;
        hdr_cnt = '0;
        if (b[6:0] == LenCode16) begin
          ph = PhExt16;
        end else if (b[6:0] == LenCode64) begin
          ph = PhExt64;
        end else begin
          tot_len = LenW'(b[6:0]);
          length_known();
        end
      end
      PhExt16, PhExt64: begin
        // big-endian shift-in, bit 63 of a 64-bit length falls off the top
        tot_len = {tot_len[LenW-9:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= ((ph == PhExt16) ? 4'd2 : 4'd8)) length_known();
      end
      PhKey: begin
        key     = {key[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= 4'd4) begin
          hdr_cnt = '0;
          ph = (tot_len != '0) ? PhPayload : PhHdr0;
        end
      end
      PhPayload: begin
        w.data  = b ^ key[8*(3-int'(key_idx)) +: 8];
        key_idx = key_idx + 2'd1;
        if (rem_len != '0) rem_len = rem_len - 1'b1;
        w.last   = (rem_len == '0);
        w.opcode = hdr_op;
        w.fin    = hdr_fin;
        w.length = tot_len;
        payload_expect_q.push_back(w);
        n_predicted++;
        if (w.last) ph = PhHdr0;
      end
      default: begin
        hdr_fin = b[7];
        hdr_op  = b[3:0];
        ph      = PhHdr1;
      end
    endcase
  endfunction

  // fill < 0 gives random payload, otherwise every payload word is fill
  task automatic push_frame(input logic [7:0] b0, input logic mask_bit, input int len,
                            input len_form_e form, input logic top, input int fill);
    logic [31:0] mkey;
    int i;
    mkey = $urandom();
    stream_q.push_back(b0);
    case (form)
      LenExt16: begin
        stream_q.push_back({mask_bit, LenCode16});
        stream_q.push_back(8'(len >> 8));
        stream_q.push_back(8'(len));
      end
      LenExt64: begin
        stream_q.push_back({mask_bit, LenCode64});
        stream_q.push_back({top, 7'b0});
        for (i = 6; i >= 0; i--) stream_q.push_back(8'(len >> (8 * i)));
      end
      default: begin
        stream_q.push_back({mask_bit, 7'(len)});
      end
    endcase
    if (mask_bit) begin
      for (i = 3; i >= 0; i--) stream_q.push_back(mkey[8*i +: 8]);
    end
    for (i = 0; i < len; i++) stream_q.push_back((fill < 0) ? 8'($urandom()) : 8'(fill));
    n_frames++;
    if (mask_bit) n_masked++;
    if (len == 0) n_empty++;
  endtask

  // driver: a word stays on the bus until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (stream_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tdata  <= stream_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_on && ($urandom_range(99) >= rx_stall_pct);
  end

  // monitor: predict on input words, check output words, watch for a hang
  always @(posedge clk_i) begin
    payload_word_t w;
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        n_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_out++;
        if (payload_expect_q.size() == 0) begin
          n_errors++;
          if (n_errors <= ReportMax)
            $display("payload word %0d: none expected, got data %h last %b op %h fin %b len %0d",
                     n_out, m_axis_tdata[7:0], m_axis_tlast, m_axis_tuser[3:0],
                     m_axis_tuser[4], m_axis_tdata[70:8]);
        end else begin
          w = payload_expect_q.pop_front();
          if (m_axis_tdata[7:0] !== w.data || m_axis_tlast !== w.last ||
              m_axis_tuser[3:0] !== w.opcode || m_axis_tuser[4] !== w.fin ||
              m_axis_tdata[70:8] !== w.length) begin
            n_errors++;
            if (n_errors <= ReportMax)
              $display("payload word %0d: expected data %h last %b op %h fin %b len %0d, got data %h last %b op %h fin %b len %0d",
                       n_out, w.data, w.last, w.opcode, w.fin, w.length,
                       m_axis_tdata[7:0], m_axis_tlast, m_axis_tuser[3:0],
                       m_axis_tuser[4], m_axis_tdata[70:8]);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("watchdog: no word moved for %0d cycles, %0d payload words outstanding",
                   StallLimit, payload_expect_q.size());
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned total;
    int unsigned r;
    int len;

    // directed: non-minimal 16-bit length, empty frames with and without key,
    // all-ones header with key, 64-bit length whose top bit is dropped
    push_frame(8'h00, 1'b0, 1, LenExt16, 1'b0, 8'hFF);
    push_frame(8'h8A, 1'b0, 0, LenDirect, 1'b0, 0);
    push_frame(8'h09, 1'b1, 0, LenDirect, 1'b0, 0);
    push_frame(8'hFF, 1'b1, 2, LenDirect, 1'b0, 8'h00);
    push_frame(8'h70, 1'b0, 1, LenExt64, 1'b1, 8'hA5);

    // random frames, mostly short, every header bit random
    while (stream_q.size() < StreamWords) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(12);
        push_frame(8'($urandom()), 1'($urandom()), len, LenDirect, 1'b0, -1);
      end else if (r < 82) begin
        len = $urandom_range(125, 13);
        push_frame(8'($urandom()), 1'($urandom()), len, LenDirect, 1'b0, -1);
      end else if (r < 94) begin
        len = $urandom_range(150);
        push_frame(8'($urandom()), 1'($urandom()), len, LenExt16, 1'b0, -1);
      end else begin
        len = $urandom_range(40);
        push_frame(8'($urandom()), 1'($urandom()), len, LenExt64, 1'($urandom()), -1);
      end
    end
    total = stream_q.size();

    tx_idle_pct  = 20;
    rx_stall_pct = 69;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (n_in >= total / 3);
    tx_idle_pct  = 69;
    rx_stall_pct = 20;
    wait (n_in >= 2 * total / 3);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;

    // long output stall so the decoder backs up into its input
    hold_on = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    hold_on = 1'b0;

    wait (n_in == total);
    wait (n_out >= n_predicted);
    repeat (10) @(posedge clk_i);

    $display("ran %0d frames (%0d masked, %0d empty) as %0d stream words",
             n_frames, n_masked, n_empty, n_in);
    $display("checked %0d payload words, %0d mismatches", n_out, n_errors);
    if (n_errors == 0 && payload_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
